FILE: rtl/core/abd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abd_pkg;

   localparam int NUM_CLASSES = 80;
   localparam int TABLE_DEPTH = 256;
   localparam int NUM_ANCHORS = 3;

   localparam logic [6:0] CLASS_NONE = 7'd127;
   localparam logic [6:0] CNT_MAX    = 7'd127;

   localparam logic CMD_TABLE = 1'b0;
   localparam logic CMD_CELL  = 1'b1;

   // register indexes
   localparam logic [2:0] REG_CONF_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_GRID_STRIDE    = 3'd1;
   localparam logic [2:0] REG_ANCHOR_W0      = 3'd2;
   localparam logic [2:0] REG_ANCHOR_H0      = 3'd3;
   localparam logic [2:0] REG_ANCHOR_W1      = 3'd4;
   localparam logic [2:0] REG_ANCHOR_H1      = 3'd5;
   localparam logic [2:0] REG_ANCHOR_W2      = 3'd6;
   localparam logic [2:0] REG_ANCHOR_H2      = 3'd7;

   typedef struct packed {
      logic              cmd;
      logic [7:0]        table_index;
      logic [15:0]       table_value;
      logic signed [7:0] channel_value;
      logic              channel_last;
      logic [7:0]        cell_row;
      logic [7:0]        cell_col;
      logic [1:0]        anchor_sel;
   } abd_req_type;

   typedef struct packed {
      logic signed [19:0] box_left;
      logic signed [19:0] box_top;
      logic [16:0]        box_width;
      logic [16:0]        box_height;
      logic signed [7:0]  class_id;
      logic [15:0]        class_score;
   } abd_rsp_type;

   typedef struct packed {
      logic signed [7:0] conf_threshold;
      logic [6:0]        grid_stride;
      logic [2:0][9:0]   anchor_w;
      logic [2:0][9:0]   anchor_h;
   } abd_cfg_type;

   // table read source during the decode sequence
   typedef enum logic [2:0] {
      SRC_W = 3'd0,
      SRC_H = 3'd1,
      SRC_X = 3'd2,
      SRC_Y = 3'd3,
      SRC_S = 3'd4
   } abd_src_type;

   typedef struct packed {
      logic        accept;
      abd_src_type rd_src;
      logic        sqw_en;
      logic        sqh_en;
      logic        qw_en;
      logic        qh_en;
      logic        px_en;
      logic        py_en;
      logic        left_en;
      logic        out_load;
   } abd_cmd_type;

   typedef struct packed {
      logic hit;
      logic out_free;
   } abd_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/abd_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module abd_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [4:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output abd_pkg::abd_cfg_type     cfg
);
   import abd_pkg::*;

   abd_cfg_type cfg_ff;
   abd_cfg_type cfg_in;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CONF_THRESHOLD: cfg_in.conf_threshold = signed'(csr_pwdata[7:0]);
            REG_GRID_STRIDE:    cfg_in.grid_stride    = csr_pwdata[6:0];
            REG_ANCHOR_W0:      cfg_in.anchor_w[0]    = csr_pwdata[9:0];
            REG_ANCHOR_H0:      cfg_in.anchor_h[0]    = csr_pwdata[9:0];
            REG_ANCHOR_W1:      cfg_in.anchor_w[1]    = csr_pwdata[9:0];
            REG_ANCHOR_H1:      cfg_in.anchor_h[1]    = csr_pwdata[9:0];
            REG_ANCHOR_W2:      cfg_in.anchor_w[2]    = csr_pwdata[9:0];
            REG_ANCHOR_H2:      cfg_in.anchor_h[2]    = csr_pwdata[9:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_threshold <= 8'sd0;
         cfg_ff.grid_stride    <= 7'd8;
         cfg_ff.anchor_w[0]    <= 10'd10;
         cfg_ff.anchor_h[0]    <= 10'd13;
         cfg_ff.anchor_w[1]    <= 10'd16;
         cfg_ff.anchor_h[1]    <= 10'd30;
         cfg_ff.anchor_w[2]    <= 10'd33;
         cfg_ff.anchor_h[2]    <= 10'd23;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CONF_THRESHOLD: csr_prdata = {24'd0, cfg_ff.conf_threshold};
         REG_GRID_STRIDE:    csr_prdata = {25'd0, cfg_ff.grid_stride};
         REG_ANCHOR_W0:      csr_prdata = {22'd0, cfg_ff.anchor_w[0]};
         REG_ANCHOR_H0:      csr_prdata = {22'd0, cfg_ff.anchor_h[0]};
         REG_ANCHOR_W1:      csr_prdata = {22'd0, cfg_ff.anchor_w[1]};
         REG_ANCHOR_H1:      csr_prdata = {22'd0, cfg_ff.anchor_h[1]};
         REG_ANCHOR_W2:      csr_prdata = {22'd0, cfg_ff.anchor_w[2]};
         REG_ANCHOR_H2:      csr_prdata = {22'd0, cfg_ff.anchor_h[2]};
         default:            csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/abd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module abd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire abd_pkg::abd_status_type status,
   output abd_pkg::abd_cmd_type        cmd
);
   import abd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD_W = 6'b000010,
      ST_RD_H = 6'b000100,
      ST_RD_X = 6'b001000,
      ST_RD_Y = 6'b010000,
      ST_FIN  = 6'b100000
   } abd_state_type;

   abd_state_type state_ff;
   abd_state_type state_in;
   logic          rd_s_ff;   // score read cycle, between RD_Y and FIN
   logic          rd_s_in;

   assign req_stall = (state_ff != ST_IDLE) || rd_s_ff;

   always_comb begin
      state_in = state_ff;
      rd_s_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.hit) state_in = ST_RD_W;
         end
         ST_RD_W: state_in = ST_RD_H;
         ST_RD_H: state_in = ST_RD_X;
         ST_RD_X: state_in = ST_RD_Y;
         ST_RD_Y: begin
            state_in = ST_FIN;
            rd_s_in  = 1'b1;
         end
         ST_FIN: begin
            if (!rd_s_ff && status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_s_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_s_ff  <= rd_s_in;
      end
   end

   always_comb begin
      cmd.accept   = req_valid && !req_stall;
      cmd.sqw_en   = (state_ff == ST_RD_H);
      cmd.sqh_en   = (state_ff == ST_RD_X);
      cmd.qw_en    = (state_ff == ST_RD_X);
      cmd.qh_en    = (state_ff == ST_RD_Y);
      cmd.px_en    = (state_ff == ST_RD_Y);
      cmd.py_en    = rd_s_ff;
      cmd.left_en  = rd_s_ff;
      cmd.out_load = (state_ff == ST_FIN) && !rd_s_ff && status.out_free;
      case (state_ff)
         ST_RD_W: cmd.rd_src = SRC_W;
         ST_RD_H: cmd.rd_src = SRC_H;
         ST_RD_X: cmd.rd_src = SRC_X;
         ST_RD_Y: cmd.rd_src = SRC_Y;
         default: cmd.rd_src = SRC_S;
      endcase
   end

   a_seq_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD_W |-> ##5 (state_ff == ST_FIN && !rd_s_ff))
      else $error("decode sequence length broken");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (state_ff == ST_IDLE))
      else $error("no return to idle after result load");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !rd_s_ff && !status.out_free) |=> (state_ff == ST_FIN))
      else $error("result dropped while output register busy");

endmodule

`default_nettype wire

FILE: rtl/core/abd_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module abd_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire abd_pkg::abd_req_type req_data,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output abd_pkg::abd_rsp_type      rsp_data,
   input  wire abd_pkg::abd_cfg_type cfg,
   input  wire abd_pkg::abd_cmd_type cmd,
   output abd_pkg::abd_status_type   status
);
   import abd_pkg::*;

   // edge = trunc((p * 2^15 - q) / 2^27), saturated to 20 bits signed
   function automatic logic signed [19:0] edge_calc(input logic signed [33:0] p,
                                                    input logic [41:0] q);
      logic signed [49:0] d;
      logic signed [49:0] dr;
      logic signed [22:0] t;
      d  = (50'(p) <<< 15) - signed'(50'(q));
      dr = d + ((d < 0) ? 50'sd134217727 : 50'sd0);
      t  = 23'(dr >>> 27);
      if (t > 23'sd524287)       edge_calc = 20'sd524287;
      else if (t < -23'sd524288) edge_calc = -20'sd524288;
      else                       edge_calc = 20'(t);
   endfunction

   // sigmoid table
   logic [15:0] table_mem [TABLE_DEPTH];
   logic [15:0] rdata_ff;
   logic [7:0]  rd_addr;
   logic        tbl_we;
   logic        cell_we;

   // per-cell running state
   logic [6:0]        cnt_ff, cnt_in;
   logic [3:0][7:0]   geo_ff, geo_in;
   logic signed [7:0] obj_ff, obj_in;
   logic signed [7:0] best_ff, best_in;
   logic [6:0]        bcls_ff, bcls_in;
   logic [6:0]        cls;
   logic              cls_upd;

   // captured cell for the decode sequence
   logic [3:0][7:0]   job_geo_ff;
   logic [7:0]        job_best_ff;
   logic [6:0]        job_cls_ff;
   logic [7:0]        job_row_ff;
   logic [7:0]        job_col_ff;
   logic [1:0]        job_anc_ff;
   logic [1:0]        anc_sat;

   // arithmetic pipeline
   logic [31:0]        sqw_ff, sqh_ff;
   logic [41:0]        qw_ff, qh_ff;
   logic signed [33:0] px_ff, py_ff;
   logic signed [33:0] pos_prod;
   logic signed [25:0] nval;
   logic [7:0]         pos_sel;
   logic signed [19:0] left_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   abd_rsp_type rsp_data_ff;

   assign tbl_we  = cmd.accept && (req_data.cmd == CMD_TABLE);
   assign cell_we = cmd.accept && (req_data.cmd == CMD_CELL);

   always_comb begin
      case (cmd.rd_src)
         SRC_W:   rd_addr = job_geo_ff[2];
         SRC_H:   rd_addr = job_geo_ff[3];
         SRC_X:   rd_addr = job_geo_ff[0];
         SRC_Y:   rd_addr = job_geo_ff[1];
         default: rd_addr = job_best_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_we) table_mem[req_data.table_index] <= req_data.table_value;
      rdata_ff <= table_mem[rd_addr];
   end

   // fold the incoming byte into the cell state
   always_comb begin
      geo_in  = geo_ff;
      obj_in  = obj_ff;
      best_in = best_ff;
      bcls_in = bcls_ff;
      cls     = cnt_ff - 7'd5;
      cls_upd = (cnt_ff >= 7'd5) && (cls < 7'(NUM_CLASSES)) &&
                (req_data.channel_value > best_ff);
      if (cnt_ff < 7'd4) geo_in[cnt_ff[1:0]] = req_data.channel_value;
      if (cnt_ff == 7'd4) obj_in = req_data.channel_value;
      if (cls_upd) begin
         best_in = req_data.channel_value;
         bcls_in = cls;
      end
      cnt_in = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 7'd1;
   end

   assign status.hit      = (req_data.cmd == CMD_CELL) && req_data.channel_last &&
                            (obj_in > cfg.conf_threshold);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 7'd0;
         geo_ff  <= '0;
         obj_ff  <= 8'sd0;
         best_ff <= -8'sd128;
         bcls_ff <= CLASS_NONE;
      end else if (cell_we) begin
         if (req_data.channel_last) begin
            cnt_ff  <= 7'd0;
            geo_ff  <= '0;
            obj_ff  <= 8'sd0;
            best_ff <= -8'sd128;
            bcls_ff <= CLASS_NONE;
         end else begin
            cnt_ff  <= cnt_in;
            geo_ff  <= geo_in;
            obj_ff  <= obj_in;
            best_ff <= best_in;
            bcls_ff <= bcls_in;
         end
      end
   end

   assign anc_sat = (req_data.anchor_sel >= 2'(NUM_ANCHORS)) ? 2'(NUM_ANCHORS - 1)
                                                              : req_data.anchor_sel;

   always_ff @(posedge clock) begin
      if (cell_we && req_data.channel_last) begin
         job_geo_ff  <= geo_in;
         job_best_ff <= best_in;
         job_cls_ff  <= bcls_in;
         job_row_ff  <= req_data.cell_row;
         job_col_ff  <= req_data.cell_col;
         job_anc_ff  <= anc_sat;
      end
   end

   // center numerator: 2*s + 65536*pos - 32768, times stride
   assign pos_sel  = cmd.px_en ? job_col_ff : job_row_ff;
   assign nval     = signed'(26'({rdata_ff, 1'b0})) + signed'(26'({pos_sel, 16'h0000}))
                     - 26'sd32768;
   assign pos_prod = nval * signed'({1'b0, cfg.grid_stride});

   always_ff @(posedge clock) begin
      if (cmd.sqw_en)  sqw_ff  <= rdata_ff * rdata_ff;
      if (cmd.sqh_en)  sqh_ff  <= rdata_ff * rdata_ff;
      if (cmd.qw_en)   qw_ff   <= sqw_ff * cfg.anchor_w[job_anc_ff];
      if (cmd.qh_en)   qh_ff   <= sqh_ff * cfg.anchor_h[job_anc_ff];
      if (cmd.px_en)   px_ff   <= pos_prod;
      if (cmd.py_en)   py_ff   <= pos_prod;
      if (cmd.left_en) left_ff <= edge_calc(px_ff, qw_ff);
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.box_left    <= left_ff;
         rsp_data_ff.box_top     <= edge_calc(py_ff, qh_ff);
         rsp_data_ff.box_width   <= {1'b0, qw_ff[41:26]};
         rsp_data_ff.box_height  <= {1'b0, qh_ff[41:26]};
         rsp_data_ff.class_id    <= (job_cls_ff == CLASS_NONE) ? -8'sd1
                                                               : signed'({1'b0, job_cls_ff});
         rsp_data_ff.class_score <= rdata_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_tbl_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.sqw_en || cmd.qh_en || cmd.py_en) |-> !tbl_we)
      else $error("table written during decode");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over pending result");

   a_cell_clear: assert property (@(posedge clock) disable iff (reset)
      (cell_we && req_data.channel_last) |=> (cnt_ff == 7'd0 && bcls_ff == CLASS_NONE))
      else $error("cell state not cleared after last byte");

endmodule

`default_nettype wire

FILE: rtl/core/anchor_box_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  abd_req_type: table write or one cell byte
// rsp_      out        rsp_valid / rsp_stall  abd_rsp_type: decoded box, class, score
// csr_      in/out     APB setup + access     8 registers at byte address 4*i
//
// Table writes and cell bytes stream at one per cycle while req_stall is low.
// A last byte that passes the objectness threshold holds req_stall through five
// table reads through the single read port, four feeding the multiplier chain and
// the last the score, then the result load, which waits while rsp_stall holds a result.
// Reset is synchronous; no clearing pass: table entries are undefined until written.
// A finished result waits in the output register while new items are taken.

module anchor_box_decode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire abd_pkg::abd_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output abd_pkg::abd_rsp_type      rsp_data,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [4:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import abd_pkg::*;

   abd_cfg_type    cfg;
   abd_cmd_type    cmd;
   abd_status_type status;

   // register file: threshold, stride, anchor sizes
   abd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: accept transactions, step the decode, hand off the result
   abd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table memory, running argmax, box arithmetic and output register
   abd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import abd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASES        = 6;
   localparam int PRESSURE_HOLD = 300;

   // How the expected outcome of one transaction is formed: from the predictor,
   // or typed into the directed table (no result, or a fixed box).
   typedef enum logic [1:0] {NOTE_MODEL, NOTE_NONE, NOTE_BOX} outcome_type;

   typedef struct packed {
      outcome_type kind;
      abd_rsp_type box;
   } item_note_type;

   typedef struct packed {
      abd_req_type   item;
      item_note_type note;
   } directed_row_type;

   localparam item_note_type MODEL_NOTE = '{kind: NOTE_MODEL, box: '0};
   localparam item_note_type NONE_NOTE  = '{kind: NOTE_NONE, box: '0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   abd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   abd_rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   anchor_box_decode dut (.*);

   // ---------------------------------------------------------------------------
   // Predictor state: register copies, sigmoid table, per-cell accumulators
   // ---------------------------------------------------------------------------
   logic signed [7:0] thr_reg = 8'sd0;
   logic [6:0]        stride_reg = 7'd8;
   logic [9:0]        anchor_w_reg [NUM_ANCHORS] = '{10'd10, 10'd16, 10'd33};
   logic [9:0]        anchor_h_reg [NUM_ANCHORS] = '{10'd13, 10'd30, 10'd23};

   logic [15:0] sig_lut [TABLE_DEPTH];
   logic [6:0]  ch_count = '0;
   logic [7:0]  geom [4] = '{8'd0, 8'd0, 8'd0, 8'd0};
   logic [7:0]  obj_byte = '0;
   logic [7:0]  best_byte = 8'h80;
   logic [6:0]  best_cls = CLASS_NONE;

   // Expected boxes in arrival order, and one note per offered transaction
   abd_rsp_type   boxes_due [$];
   item_note_type note_q [$];

   int failures = 0;
   int items_sent = 0;
   int boxes_checked = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_holdoff = 0;

   function automatic void clear_cell();
      ch_count = '0;
      for (int g = 0; g < 4; g++) geom[g] = '0;
      obj_byte = '0;
      best_byte = 8'h80;
      best_cls = CLASS_NONE;
   endfunction

   // Left or top edge in 1/16 pixel: exact value scaled by 2^32, truncated toward
   // zero, then saturated to 20 signed bits.
   function automatic logic signed [19:0] box_edge(input logic [15:0] s,
                                                   input logic [7:0] pos,
                                                   input longint unsigned sq);
      longint n, v, t;
      n = 2 * longint'(s) + 65536 * longint'(pos) - 32768;
      v = n * longint'(stride_reg) * 1048576 - longint'(sq >> 1);
      if (v < 0) begin
         t = -((-v) >>> 32);
      end else begin
         t = v >>> 32;
      end
      if (t > 524287) begin
         t = 524287;
      end else if (t < -524288) begin
         t = -524288;
      end
      return t[19:0];
   endfunction

   // Advance the cell state by one transaction; return 1 and fill box when a
   // decoded box comes out of it.
   function automatic bit predict_box(input abd_req_type item, output abd_rsp_type box);
      logic [7:0]        b;
      logic [6:0]        cls;
      int                a;
      longint unsigned   wq, hq, wpx, hpx;
      box = '0;
      if (item.cmd == CMD_TABLE) begin
         sig_lut[item.table_index] = item.table_value;
         return 1'b0;
      end
      b = item.channel_value;
      if (ch_count < 4) begin
         geom[ch_count[1:0]] = b;
      end else if (ch_count == 4) begin
         obj_byte = b;
      end else begin
         cls = ch_count - 7'd5;
         if (cls < NUM_CLASSES && $signed(b) > $signed(best_byte)) begin
            best_byte = b;
            best_cls = cls;
         end
      end
      if (ch_count != CNT_MAX) ch_count++;
      if (!item.channel_last) return 1'b0;
      if ($signed(obj_byte) <= thr_reg) begin
         clear_cell();
         return 1'b0;
      end
      a = (item.anchor_sel >= NUM_ANCHORS) ? NUM_ANCHORS - 1 : int'(item.anchor_sel);
      wq = sig_lut[geom[2]];
      wq = wq * sig_lut[geom[2]] * anchor_w_reg[a] * 64;
      hq = sig_lut[geom[3]];
      hq = hq * sig_lut[geom[3]] * anchor_h_reg[a] * 64;
      wpx = wq >> 32;
      hpx = hq >> 32;
      box.box_left    = box_edge(sig_lut[geom[0]], item.cell_col, wq);
      box.box_top     = box_edge(sig_lut[geom[1]], item.cell_row, hq);
      box.box_width   = (wpx > 131071) ? 17'h1FFFF : wpx[16:0];
      box.box_height  = (hpx > 131071) ? 17'h1FFFF : hpx[16:0];
      box.class_id    = (best_cls == CLASS_NONE) ? -8'sd1 : {1'b0, best_cls};
      box.class_score = sig_lut[best_byte];
      clear_cell();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Clock, timeout
   // ---------------------------------------------------------------------------
   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles, %0d boxes still due", CYCLE_LIMIT,
               boxes_due.size());
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Monitor: predict on every accepted request, check every accepted result.
   // Everything is sampled at the rising edge; inputs move on the falling edge.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      item_note_type note;
      abd_rsp_type   box, want;
      bit            hit;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            note = note_q.pop_front();
            hit = predict_box(req_data, box);
            // Typed rows override the predictor, which still tracks the state
            if (note.kind == NOTE_BOX) begin
               boxes_due.push_back(note.box);
            end else if (note.kind == NOTE_MODEL && hit) begin
               boxes_due.push_back(box);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (boxes_due.size() == 0) begin
               $error("unexpected box transaction: left %0d top %0d class %0d",
                      $signed(rsp_data.box_left), $signed(rsp_data.box_top),
                      $signed(rsp_data.class_id));
               failures++;
            end else begin
               want = boxes_due.pop_front();
               boxes_checked++;
               if (rsp_data.box_left !== want.box_left) begin
                  $error("box_left: expected %0d, actual %0d",
                         $signed(want.box_left), $signed(rsp_data.box_left));
                  failures++;
               end
               if (rsp_data.box_top !== want.box_top) begin
                  $error("box_top: expected %0d, actual %0d",
                         $signed(want.box_top), $signed(rsp_data.box_top));
                  failures++;
               end
               if (rsp_data.box_width !== want.box_width) begin
                  $error("box_width: expected %0d, actual %0d",
                         want.box_width, rsp_data.box_width);
                  failures++;
               end
               if (rsp_data.box_height !== want.box_height) begin
                  $error("box_height: expected %0d, actual %0d",
                         want.box_height, rsp_data.box_height);
                  failures++;
               end
               if (rsp_data.class_id !== want.class_id) begin
                  $error("class_id: expected %0d, actual %0d",
                         $signed(want.class_id), $signed(rsp_data.class_id));
                  failures++;
               end
               if (rsp_data.class_score !== want.class_score) begin
                  $error("class_score: expected %0d, actual %0d",
                         want.class_score, rsp_data.class_score);
                  failures++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result side: stall at the phase's rate, or hold off for a long stretch when
   // the stimulus asks for back-pressure.
   // ---------------------------------------------------------------------------
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (rsp_holdoff > 0) begin
            rsp_stall <= 1'b1;
            rsp_holdoff--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic abd_req_type mk_item(input logic cmd, input int idx, input int val,
                                           input int chv, input logic last, input int row,
                                           input int col, input int anc);
      abd_req_type item;
      item.cmd           = cmd;
      item.table_index   = idx[7:0];
      item.table_value   = val[15:0];
      item.channel_value = chv[7:0];
      item.channel_last  = last;
      item.cell_row      = row[7:0];
      item.cell_col      = col[7:0];
      item.anchor_sel    = anc[1:0];
      return item;
   endfunction

   // Fill every field at random; callers pin the ones that matter
   function automatic abd_req_type random_item(input logic cmd);
      return mk_item(cmd, $urandom_range(255), $urandom_range(65535), $urandom_range(255),
                     $urandom_range(1), $urandom_range(255), $urandom_range(255),
                     $urandom_range(3));
   endfunction

   // Offer one transaction. Entered and left on a falling edge; idle cycles
   // drop valid, and the payload holds while the block stalls.
   task automatic offer(input abd_req_type item, input item_note_type note);
      note_q.push_back(note);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // Let every expected box arrive, then give the decode pipe time to settle
   task automatic drain();
      req_valid <= 1'b0;
      while (boxes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // One APB write, setup then access; psel stays high for back-to-back writes
   task automatic csr_write(input logic [2:0] idx, input int value);
      logic [31:0] wdata;
      wdata = '0;
      case (idx)
         REG_CONF_THRESHOLD: begin
            thr_reg = value[7:0];
            wdata[7:0] = value[7:0];
         end
         REG_GRID_STRIDE: begin
            stride_reg = value[6:0];
            wdata[6:0] = value[6:0];
         end
         REG_ANCHOR_W0: begin
            anchor_w_reg[0] = value[9:0];
            wdata[9:0] = value[9:0];
         end
         REG_ANCHOR_H0: begin
            anchor_h_reg[0] = value[9:0];
            wdata[9:0] = value[9:0];
         end
         REG_ANCHOR_W1: begin
            anchor_w_reg[1] = value[9:0];
            wdata[9:0] = value[9:0];
         end
         REG_ANCHOR_H1: begin
            anchor_h_reg[1] = value[9:0];
            wdata[9:0] = value[9:0];
         end
         REG_ANCHOR_W2: begin
            anchor_w_reg[2] = value[9:0];
            wdata[9:0] = value[9:0];
         end
         REG_ANCHOR_H2: begin
            anchor_h_reg[2] = value[9:0];
            wdata[9:0] = value[9:0];
         end
         default: begin
         end
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   // One cell: four geometry bytes, objectness, then class scores. Most cells
   // are short and well formed so boxes come often; some run up to the full class
   // range, some overflow it, at times past the channel counter's ceiling, and a
   // few end early before objectness. Table writes are sprinkled in as noise.
   task automatic random_cell();
      logic [7:0]  bytes [$];
      abd_req_type item;
      int          kind, n_cls, n_bytes, t, obj;
      bit          floor_cell;
      kind = $urandom_range(99);
      floor_cell = ($urandom_range(3) == 0);
      t = int'(thr_reg);
      for (int g = 0; g < 4; g++) bytes.push_back(8'($urandom_range(255)));
      // Bias objectness above threshold so most cells produce a box
      if (t < 127 && $urandom_range(99) < 80) begin
         obj = t + 1 + $urandom_range(126 - t);
      end else begin
         obj = $urandom_range(255);
      end
      bytes.push_back(obj[7:0]);
      if (kind < 80) begin
         n_cls = $urandom_range(4);
      end else if (kind < 92) begin
         n_cls = $urandom_range(NUM_CLASSES, 5);
      end else if (kind < 95) begin
         n_cls = $urandom_range(130, 100);
      end else begin
         n_cls = -1;
      end
      if (n_cls < 0) begin
         n_bytes = $urandom_range(4, 1);
      end else begin
         for (int c = 0; c < n_cls; c++) begin
            if (floor_cell || $urandom_range(9) == 0) begin
               bytes.push_back(8'h80);
            end else begin
               bytes.push_back(8'($urandom_range(255)));
            end
         end
         n_bytes = bytes.size();
      end
      for (int k = 0; k < n_bytes; k++) begin
         if ($urandom_range(99) < 4) offer(random_item(CMD_TABLE), MODEL_NOTE);
         item = random_item(CMD_CELL);
         item.channel_value = bytes[k];
         item.channel_last  = (k == n_bytes - 1);
         offer(item, MODEL_NOTE);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      directed_row_type rows [$];
      abd_req_type      item;
      abd_rsp_type      unit_box;
      int               setv [8];
      int               phase_end;
      clear_cell();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Lone last byte as the first cell byte after reset: objectness is still zero, which
      // does not beat the zero threshold, so nothing comes out.
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 0, 1'b1, 0, 0, 0), note: NONE_NOTE});

      // Fill the whole sigmoid table first so no unwritten entry is ever read
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         item = random_item(CMD_TABLE);
         item.table_index = i[7:0];
         offer(item, MODEL_NOTE);
      end

      // Pin a few entries: byte 0 reads as one half, -128 as zero, 127 as the
      // top code, -1 as the smallest nonzero code. Last is set on three of them to
      // show that a table write ignores it.
      rows.push_back('{item: mk_item(CMD_TABLE, 0, 32768, -1, 1'b1, 255, 255, 3),
                       note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_TABLE, 128, 0, 127, 1'b1, 0, 0, 0),
                       note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_TABLE, 127, 65535, -128, 1'b1, 255, 0, 2),
                       note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_TABLE, 255, 1, 0, 1'b0, 0, 255, 1),
                       note: MODEL_NOTE});

      // All-half geometry at the reset settings (stride 8, anchor 10 x 13), no
      // class channels: center 4 px, size 10 x 13 px, class none.
      unit_box = '{box_left: -20'sd16, box_top: -20'sd40, box_width: 17'd160,
                   box_height: 17'd208, class_id: -8'sd1, class_score: 16'd0};
      for (int g = 0; g < 4; g++) begin
         rows.push_back('{item: mk_item(CMD_CELL, 255, 65535, 0, 1'b0, 255, 255, 3),
                          note: MODEL_NOTE});
      end
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 127, 1'b1, 0, 0, 0),
                       note: '{kind: NOTE_BOX, box: unit_box}});

      // Extreme geometry, class floor first, a tie that must not win, then the
      // top score; last cell at the far grid corner with an out-of-range anchor.
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 127, 1'b0, 0, 0, 0), note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, -128, 1'b0, 0, 0, 0), note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, -1, 1'b0, 0, 0, 0), note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 127, 1'b0, 0, 0, 0), note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 1, 1'b0, 0, 0, 0), note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, -128, 1'b0, 0, 0, 0), note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 5, 1'b0, 0, 0, 0), note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 5, 1'b0, 0, 0, 0), note: MODEL_NOTE});
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 127, 1'b1, 255, 255, 3),
                       note: MODEL_NOTE});

      // Objectness equal to the threshold is dropped
      for (int g = 0; g < 4; g++) begin
         rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 0, 1'b0, 9, 9, 0), note: MODEL_NOTE});
      end
      rows.push_back('{item: mk_item(CMD_CELL, 0, 0, 0, 1'b1, 9, 9, 0), note: NONE_NOTE});

      foreach (rows[r]) offer(rows[r].item, rows[r].note);

      // Random phases, each with its own register setting and idle pattern
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: begin
               setv[REG_CONF_THRESHOLD] = -128;
               setv[REG_GRID_STRIDE]    = 1;
               for (int r = REG_ANCHOR_W0; r <= REG_ANCHOR_H2; r++) setv[r] = 0;
            end
            1: begin
               setv[REG_CONF_THRESHOLD] = 126;
               setv[REG_GRID_STRIDE]    = 64;
               for (int r = REG_ANCHOR_W0; r <= REG_ANCHOR_H2; r++) setv[r] = 1023;
            end
            2: begin
               setv[REG_CONF_THRESHOLD] = int'($urandom_range(31)) - 16;
               setv[REG_GRID_STRIDE]    = $urandom_range(64, 1);
               for (int r = REG_ANCHOR_W0; r <= REG_ANCHOR_H2; r++) begin
                  setv[r] = $urandom_range(1023);
               end
            end
            3: begin
               // Stride zero is outside the usual range: centers collapse to 0
               setv[REG_CONF_THRESHOLD] = -1;
               setv[REG_GRID_STRIDE]    = 0;
               for (int r = REG_ANCHOR_W0; r <= REG_ANCHOR_H2; r++) begin
                  setv[r] = $urandom_range(1023);
               end
            end
            4: begin
               setv[REG_CONF_THRESHOLD] = 50;
               setv[REG_GRID_STRIDE]    = 127;
               for (int r = REG_ANCHOR_W0; r <= REG_ANCHOR_H2; r++) begin
                  setv[r] = (r % 2 == 0) ? 1023 : 0;
               end
            end
            default: begin
               // Threshold at the top: no objectness byte can pass
               setv[REG_CONF_THRESHOLD] = 127;
               setv[REG_GRID_STRIDE]    = 8;
               setv[REG_ANCHOR_W0] = 10;
               setv[REG_ANCHOR_H0] = 13;
               setv[REG_ANCHOR_W1] = 16;
               setv[REG_ANCHOR_H1] = 30;
               setv[REG_ANCHOR_W2] = 33;
               setv[REG_ANCHOR_H2] = 23;
            end
         endcase
         for (int r = 0; r < 8; r++) csr_write(3'(r), setv[r]);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;

         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 73;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 73;
            end
            default: begin
               send_idle_pct = 21;
               rsp_stall_pct = 21;
            end
         endcase
         // Back-pressure: hold the result side off while requests keep coming,
         // so the output register fills and the block stalls its input.
         if (phase == 0) rsp_holdoff = PRESSURE_HOLD;

         phase_end = items_sent + ((phase == PHASES - 1) ? 80 : 200);
         while (items_sent < phase_end) random_cell();
      end

      drain();
      $display("Drove %0d transactions (table loads and cell bytes) over %0d register settings",
               items_sent, PHASES + 1);
      $display("Checked %0d decoded boxes field by field, %0d mismatches", boxes_checked,
               failures);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
